// ===== hdl/fixed_point_alu_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point ALU core
// Clocked implication checks with synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_CORE_ASSERT_SVH
`define FIXED_POINT_ALU_CORE_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds
`define FPA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("fpa same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante
`define FPA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("fpa next-cycle check failed");

`endif

// ===== hdl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared opcodes, control word and default sizes of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int PORT_W         = 32;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_LT     = 4'd4,
    OP_GT     = 4'd5,
    OP_LE     = 4'd6,
    OP_GE     = 4'd7,
    OP_EQ     = 4'd8,
    OP_NE     = 4'd9,
    OP_MIN    = 4'd10,
    OP_MAX    = 4'd11,
    OP_INC    = 4'd12,
    OP_DEC    = 4'd13,
    OP_TO_INT = 4'd14
  } op_t;

  // Control word that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    op_t  op;
    logic q_neg;   // sign of a product or quotient
    logic a_neg;   // dividend sign, for zero-divisor saturation
    logic b_zero;  // divisor is zero
    logic cmp;     // comparison outcome of the front stage
    logic ovf;     // saturation flag of the front stage
  } fpa_ctrl_t;

  // Working width: data width capped at the port width
  function automatic int work_width(input int dw);
    return (dw < PORT_W) ? dw : PORT_W;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fixed_point_alu_core.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Signed fixed-point ALU with rounded, saturating multiply and divide.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_op, in_operand_a and in_operand_b with start high;
//   the word is taken at a rising edge where start is high and busy is low.
//   busy is high only in the first cycle after reset; after that a new word
//   can be issued in every cycle.
//   Result channel: out_valid is high for exactly one cycle together with
//   out_result_raw and its flags. The receiver cannot stall; results leave
//   in issue order, one per accepted word.
//   Path: every operation passes one front stage, the divider chain with
//   one quotient bit per cell, and one output stage. The chain retires
//   WORK_W + FRAC_BITS quotient bits, where WORK_W is DATA_WIDTH capped
//   at 32. Throughput: one word per cycle.
//   Reset: synchronous, active low; it clears every valid bit in the chain,
//   so words in flight are dropped and no result strobe follows.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_alu_core_assert.svh"

module fixed_point_alu_core #(
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEF,
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [3:0]                       in_op,
  input  logic signed [fpa_pkg::PORT_W-1:0] in_operand_a,
  input  logic signed [fpa_pkg::PORT_W-1:0] in_operand_b,
  output logic                             out_valid,
  output logic signed [fpa_pkg::PORT_W-1:0] out_result_raw,
  output logic                             out_compare_true,
  output logic                             out_overflow,
  output logic                             out_divide_by_zero
);
  import fpa_pkg::*;

  localparam int WORK_W = work_width(DATA_WIDTH);
  localparam int NUM_W  = WORK_W + FRAC_BITS;
  localparam int SIDE_W = 2 * WORK_W;

  logic      busy_r, busy_nxt;

  fpa_ctrl_t         ctrl_c [0:NUM_W];
  logic [WORK_W-1:0] rem_c  [0:NUM_W];
  logic [NUM_W-1:0]  nq_c   [0:NUM_W];
  logic [WORK_W-1:0] den_c  [0:NUM_W];
  logic [SIDE_W-1:0] side_c [0:NUM_W];

  // Hold off the first cycle after reset, then accept every cycle
  assign busy_nxt = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

  // Decode and load the chain
  fpa_front #(
    .WORK_W    (WORK_W),
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W),
    .SIDE_W    (SIDE_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (start && !busy_r),
    .op_i   (in_op),
    .a_i    (in_operand_a),
    .b_i    (in_operand_b),
    .ctrl_o (ctrl_c[0]),
    .nq_o   (nq_c[0]),
    .den_o  (den_c[0]),
    .side_o (side_c[0])
  );

  assign rem_c[0] = '0;

  // Row of division cells, one quotient bit each
  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    fpa_div_cell #(
      .WORK_W (WORK_W),
      .NUM_W  (NUM_W),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl_i (ctrl_c[k]),
      .rem_i  (rem_c[k]),
      .nq_i   (nq_c[k]),
      .den_i  (den_c[k]),
      .side_i (side_c[k]),
      .ctrl_o (ctrl_c[k+1]),
      .rem_o  (rem_c[k+1]),
      .nq_o   (nq_c[k+1]),
      .den_o  (den_c[k+1]),
      .side_o (side_c[k+1])
    );
  end

  // Round, saturate and present the result
  fpa_back #(
    .WORK_W    (WORK_W),
    .FRAC_BITS (FRAC_BITS),
    .NUM_W     (NUM_W),
    .SIDE_W    (SIDE_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl_i             (ctrl_c[NUM_W]),
    .rem_i              (rem_c[NUM_W]),
    .nq_i               (nq_c[NUM_W]),
    .den_i              (den_c[NUM_W]),
    .side_i             (side_c[NUM_W]),
    .out_valid          (out_valid),
    .out_result_raw     (out_result_raw),
    .out_compare_true   (out_compare_true),
    .out_overflow       (out_overflow),
    .out_divide_by_zero (out_divide_by_zero)
  );

  // A word leaving the last cell strobes out on the next cycle
  `FPA_ASSERT_NXT(a_chain_to_out, clk, rst_n, ctrl_c[NUM_W].valid, out_valid)
  // An accepted word enters the chain on the next cycle
  `FPA_ASSERT_NXT(a_accept_to_chain, clk, rst_n, start && !busy_r, ctrl_c[0].valid)

endmodule

`default_nettype wire

// ===== hdl/fpa_front.sv =====
// ----------------------------------------------------------------------------
// fpa_front
// Input stage: decodes the word, resolves every operation but multiply
// and divide, forms the magnitude product and loads the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front #(
  parameter int WORK_W    = 32,
  parameter int FRAC_BITS = 8,
  parameter int NUM_W     = 40,
  parameter int SIDE_W    = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [3:0]                op_i,
  input  logic [fpa_pkg::PORT_W-1:0] a_i,
  input  logic [fpa_pkg::PORT_W-1:0] b_i,
  output fpa_pkg::fpa_ctrl_t        ctrl_o,
  output logic [NUM_W-1:0]          nq_o,
  output logic [WORK_W-1:0]         den_o,
  output logic [SIDE_W-1:0]         side_o
);
  import fpa_pkg::*;

  localparam logic [WORK_W-1:0] VMAX = {1'b0, {(WORK_W-1){1'b1}}};
  localparam logic [WORK_W-1:0] VMIN = {1'b1, {(WORK_W-1){1'b0}}};

  op_t               op;
  logic [WORK_W-1:0] a_w, b_w, mag_a, mag_b, tq, res;
  logic              a_neg, b_neg, lt, eq, cmp, ovf;
  logic [WORK_W:0]   sum, dif;
  logic [SIDE_W-1:0] prod;

  fpa_ctrl_t         ctrl_r, ctrl_nxt;
  logic [NUM_W-1:0]  nq_r, nq_nxt;
  logic [WORK_W-1:0] den_r, den_nxt;
  logic [SIDE_W-1:0] side_r, side_nxt;

  // Take the low working bits of each operand
  assign op    = op_t'(op_i);
  assign a_w   = a_i[WORK_W-1:0];
  assign b_w   = b_i[WORK_W-1:0];
  assign a_neg = a_w[WORK_W-1];
  assign b_neg = b_w[WORK_W-1];
  assign mag_a = a_neg ? (~a_w + 1'b1) : a_w;
  assign mag_b = b_neg ? (~b_w + 1'b1) : b_w;

  assign lt   = $signed(a_w) < $signed(b_w);
  assign eq   = (a_w == b_w);
  assign sum  = {a_neg, a_w} + {b_neg, b_w};
  assign dif  = {a_neg, a_w} - {b_neg, b_w};
  assign tq   = mag_a >> FRAC_BITS;
  assign prod = SIDE_W'(mag_a) * SIDE_W'(mag_b);

  // Resolve every operation but multiply and divide
  always_comb begin
    res = '0;
    cmp = 1'b0;
    ovf = 1'b0;
    case (op)
      OP_ADD: begin
        if (sum[WORK_W] != sum[WORK_W-1]) begin
          ovf = 1'b1;
          res = sum[WORK_W] ? VMIN : VMAX;
        end else begin
          res = sum[WORK_W-1:0];
        end
      end
      OP_SUB: begin
        if (dif[WORK_W] != dif[WORK_W-1]) begin
          ovf = 1'b1;
          res = dif[WORK_W] ? VMIN : VMAX;
        end else begin
          res = dif[WORK_W-1:0];
        end
      end
      OP_LT:  cmp = lt;
      OP_GT:  cmp = !lt && !eq;
      OP_LE:  cmp = lt || eq;
      OP_GE:  cmp = !lt;
      OP_EQ:  cmp = eq;
      OP_NE:  cmp = !eq;
      OP_MIN: res = lt ? a_w : b_w;
      OP_MAX: res = lt ? b_w : a_w;
      OP_INC: begin
        ovf = (a_w == VMAX);
        res = ovf ? VMAX : a_w + 1'b1;
      end
      OP_DEC: begin
        ovf = (a_w == VMIN);
        res = ovf ? VMIN : a_w - 1'b1;
      end
      OP_TO_INT: res = a_neg ? (~tq + 1'b1) : tq;
      default: res = '0;
    endcase
  end

  // Build the control word and the chain load
  always_comb begin
    ctrl_nxt        = '0;
    ctrl_nxt.valid  = accept;
    ctrl_nxt.op     = op;
    ctrl_nxt.q_neg  = a_neg ^ b_neg;
    ctrl_nxt.a_neg  = a_neg;
    ctrl_nxt.b_zero = (b_w == '0);
    ctrl_nxt.cmp    = cmp;
    ctrl_nxt.ovf    = ovf;
    nq_nxt          = NUM_W'(mag_a) << FRAC_BITS;
    den_nxt         = mag_b;
    side_nxt        = (op == OP_MUL) ? prod : SIDE_W'(res);
  end

  // Hold the control word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    nq_r   <= nq_nxt;
    den_r  <= den_nxt;
    side_r <= side_nxt;
  end

  assign ctrl_o = ctrl_r;
  assign nq_o   = nq_r;
  assign den_o  = den_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

// ===== hdl/fpa_div_cell.sv =====
// ----------------------------------------------------------------------------
// fpa_div_cell
// One restoring-division cell: retires one quotient bit and passes the
// word, with its side payload, to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_alu_core_assert.svh"

module fpa_div_cell #(
  parameter int WORK_W = 32,
  parameter int NUM_W  = 40,
  parameter int SIDE_W = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fpa_pkg::fpa_ctrl_t ctrl_i,
  input  logic [WORK_W-1:0]  rem_i,
  input  logic [NUM_W-1:0]   nq_i,
  input  logic [WORK_W-1:0]  den_i,
  input  logic [SIDE_W-1:0]  side_i,
  output fpa_pkg::fpa_ctrl_t ctrl_o,
  output logic [WORK_W-1:0]  rem_o,
  output logic [NUM_W-1:0]   nq_o,
  output logic [WORK_W-1:0]  den_o,
  output logic [SIDE_W-1:0]  side_o
);
  import fpa_pkg::*;

  logic [WORK_W:0]   shifted, diff;
  logic              take;

  fpa_ctrl_t         ctrl_r;
  logic [WORK_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0]  nq_r, nq_nxt;
  logic [WORK_W-1:0] den_r;
  logic [SIDE_W-1:0] side_r;

  // Shift in the next dividend bit and trial-subtract the divisor
  assign shifted = {rem_i, nq_i[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_i};
  assign take    = (shifted >= {1'b0, den_i});
  assign rem_nxt = take ? diff[WORK_W-1:0] : shifted[WORK_W-1:0];
  assign nq_nxt  = {nq_i[NUM_W-2:0], take};

  // Advance the control word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_i;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    nq_r   <= nq_nxt;
    den_r  <= den_i;
    side_r <= side_i;
  end

  assign ctrl_o = ctrl_r;
  assign rem_o  = rem_r;
  assign nq_o   = nq_r;
  assign den_o  = den_r;
  assign side_o = side_r;

  // Partial remainder stays below a nonzero divisor
  `FPA_ASSERT_IMP(a_rem_below_den, clk, rst_n, ctrl_r.valid && ctrl_r.op == OP_DIV && !ctrl_r.b_zero, rem_r < den_r)

endmodule

`default_nettype wire

// ===== hdl/fpa_back.sv =====
// ----------------------------------------------------------------------------
// fpa_back
// Output stage: rounds and saturates products and quotients, handles the
// zero divisor and registers the result word with its strobe.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_alu_core_assert.svh"

module fpa_back #(
  parameter int WORK_W    = 32,
  parameter int FRAC_BITS = 8,
  parameter int NUM_W     = 40,
  parameter int SIDE_W    = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fpa_pkg::fpa_ctrl_t               ctrl_i,
  input  logic [WORK_W-1:0]                rem_i,
  input  logic [NUM_W-1:0]                 nq_i,
  input  logic [WORK_W-1:0]                den_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             out_valid,
  output logic signed [fpa_pkg::PORT_W-1:0] out_result_raw,
  output logic                             out_compare_true,
  output logic                             out_overflow,
  output logic                             out_divide_by_zero
);
  import fpa_pkg::*;

  localparam int QW = NUM_W + 1;
  localparam logic [WORK_W-1:0] VMAX = {1'b0, {(WORK_W-1){1'b1}}};
  localparam logic [WORK_W-1:0] VMIN = {1'b1, {(WORK_W-1){1'b0}}};
  localparam logic [SIDE_W-1:0] HALF =
    (FRAC_BITS > 0) ? (SIDE_W'(1) << (FRAC_BITS - 1)) : '0;

  logic [WORK_W-1:0] lim, mul_m, div_m;
  logic [SIDE_W-1:0] mul_rnd, mul_big;
  logic [QW-1:0]     div_q;
  logic              mul_sat, div_sat, up;

  logic              out_valid_r, out_valid_nxt;
  logic [WORK_W-1:0] out_r_r, out_r_nxt;
  logic              out_cmp_r, out_cmp_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              out_dbz_r, out_dbz_nxt;

  // Largest magnitude allowed for the result sign
  assign lim = ctrl_i.q_neg ? VMIN : VMAX;

  // Round the product half away from zero, then clamp the magnitude
  assign mul_rnd = side_i + HALF;
  assign mul_big = mul_rnd >> FRAC_BITS;
  assign mul_sat = mul_big > SIDE_W'(lim);
  assign mul_m   = mul_sat ? lim : mul_big[WORK_W-1:0];

  // Round the quotient up when twice the remainder reaches the divisor
  assign up      = {rem_i, 1'b0} >= {1'b0, den_i};
  assign div_q   = {1'b0, nq_i} + QW'(up);
  assign div_sat = div_q > QW'(lim);
  assign div_m   = div_sat ? lim : div_q[WORK_W-1:0];

  // Select the result word
  always_comb begin
    out_valid_nxt = ctrl_i.valid;
    out_r_nxt     = side_i[WORK_W-1:0];
    out_cmp_nxt   = ctrl_i.cmp;
    out_ovf_nxt   = ctrl_i.ovf;
    out_dbz_nxt   = 1'b0;
    case (ctrl_i.op)
      OP_MUL: begin
        out_r_nxt   = ctrl_i.q_neg ? (~mul_m + 1'b1) : mul_m;
        out_ovf_nxt = mul_sat;
      end
      OP_DIV: begin
        if (ctrl_i.b_zero) begin
          out_dbz_nxt = 1'b1;
          out_ovf_nxt = 1'b0;
          out_r_nxt   = ctrl_i.a_neg ? VMIN : VMAX;
        end else begin
          out_r_nxt   = ctrl_i.q_neg ? (~div_m + 1'b1) : div_m;
          out_ovf_nxt = div_sat;
        end
      end
      default: out_r_nxt = side_i[WORK_W-1:0];
    endcase
  end

  // Hold the strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    out_r_r   <= out_r_nxt;
    out_cmp_r <= out_cmp_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_dbz_r <= out_dbz_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_raw     = PORT_W'($signed(out_r_r));
  assign out_compare_true   = out_cmp_r;
  assign out_overflow       = out_ovf_r;
  assign out_divide_by_zero = out_dbz_r;

  // Zero divisor saturates by sign and never flags overflow
  `FPA_ASSERT_IMP(a_dbz_sat, clk, rst_n, out_valid_r && out_dbz_r, !out_ovf_r && (out_r_r == VMAX || out_r_r == VMIN))
  // Comparisons give a zero result and no other flag
  `FPA_ASSERT_IMP(a_cmp_alone, clk, rst_n, out_valid_r && out_cmp_r, out_r_r == '0 && !out_ovf_r && !out_dbz_r)

endmodule

`default_nettype wire
